// ===== src/epr_pkg.sv =====
package epr_pkg;

    // Channel enables in the electrode mask
    localparam logic [5:0] CH_RF1  = 6'h01;
    localparam logic [5:0] CH_RF2  = 6'h02;
    localparam logic [5:0] CH_RF3  = 6'h04;
    localparam logic [5:0] CH_EMS1 = 6'h08;
    localparam logic [5:0] CH_EMS2 = 6'h10;
    localparam logic [5:0] CH_EMS3 = 6'h20;

    // Pole indexes
    localparam logic [1:0] POLE_FIRST   = 2'd0;
    localparam logic [1:0] POLE_SECOND  = 2'd1;
    localparam logic [1:0] POLE_LAST    = 2'd2;
    localparam logic [1:0] POLE_HEATING = 2'd3;

    // Configuration register map
    localparam int          ADDR_W            = 3;
    localparam logic        REG_SWITCH_TIME   = 1'b0;
    localparam logic [7:0]  SWITCH_TIME_RESET = 8'd170;
    // Ticks between blanking and the advance of the pair
    localparam logic [8:0]  ADVANCE_GAP       = 9'd2;

    typedef struct packed {
        logic power_on;
        logic ageing_test;
        logic rf_running;
        logic ems_running;
        logic heating;
        logic repair_work;
    } tick_t;

    typedef struct packed {
        logic [5:0] electrode_mask;
        logic [1:0] pole_index;
    } result_t;

    function automatic logic [5:0] pair_pattern(input logic [1:0] idx, input logic repair);
        logic [5:0] pat;
        unique case (idx)
            POLE_FIRST:  pat = repair ? (CH_RF1 | CH_RF2) : (CH_RF1 | CH_RF2 | CH_EMS2);
            POLE_SECOND: pat = repair ? (CH_RF2 | CH_RF3) : (CH_RF2 | CH_RF3 | CH_EMS3);
            POLE_LAST:   pat = repair ? (CH_RF1 | CH_RF3) : (CH_RF1 | CH_RF3 | CH_EMS1);
            default:     pat = CH_RF1 | CH_RF2 | CH_RF3;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/epr_core.sv =====
module epr_core
    import epr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  tick_t      tick,
    input  logic [7:0] switch_time,
    output result_t    next_result
);

    logic [7:0] tick_counter_reg, tick_counter_next;
    logic [1:0] pair_index_reg, pair_index_next;
    logic [1:0] expected_index_reg, expected_index_next;
    logic [5:0] mask_latch_reg, mask_latch_next;
    logic [7:0] count_inc;

    always_comb
    begin
        tick_counter_next   = tick_counter_reg;
        pair_index_next     = pair_index_reg;
        expected_index_next = expected_index_reg;
        mask_latch_next     = mask_latch_reg;
        count_inc           = tick_counter_reg + 8'd1;

        if (tick.power_on || tick.ageing_test)
        begin
            if (tick.rf_running || tick.ems_running)
            begin
                tick_counter_next = count_inc;
                if (count_inc == switch_time)
                begin
                    mask_latch_next = '0;
                end
                else if ({1'b0, count_inc} > ({1'b0, switch_time} + ADVANCE_GAP))
                begin
                    tick_counter_next = '0;
                    pair_index_next   = (pair_index_reg >= POLE_LAST) ? POLE_FIRST
                                                                      : pair_index_reg + 2'd1;
                end
            end
            else
            begin
                tick_counter_next = '0;
                pair_index_next   = POLE_FIRST;
                mask_latch_next   = '0;
            end

            // Latch a new pair once the index reaches the expected value
            if (pair_index_next == expected_index_reg)
            begin
                expected_index_next = (pair_index_next == POLE_LAST) ? POLE_FIRST
                                                                     : pair_index_next + 2'd1;
                if (tick.heating && tick.repair_work)
                begin
                    pair_index_next     = POLE_HEATING;
                    expected_index_next = POLE_FIRST;
                end
                mask_latch_next = pair_pattern(pair_index_next, tick.repair_work);
            end
        end
        else
        begin
            tick_counter_next   = '0;
            pair_index_next     = POLE_FIRST;
            expected_index_next = POLE_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_counter_reg   <= '0;
            pair_index_reg     <= POLE_FIRST;
            expected_index_reg <= POLE_FIRST;
            mask_latch_reg     <= '0;
        end
        else if (step)
        begin
            tick_counter_reg   <= tick_counter_next;
            pair_index_reg     <= pair_index_next;
            expected_index_reg <= expected_index_next;
            mask_latch_reg     <= mask_latch_next;
        end
    end

    assign next_result.electrode_mask = mask_latch_next;
    assign next_result.pole_index     = pair_index_next;

endmodule

// ===== src/electrode_pair_rotator.sv =====
// Electrode pair rotator.
// Input channel tick_valid/tick_ready/tick: one item per timer tick with the
// power, ageing, RF and EMS run, heating and repair-mode flags.
// Output channel result_valid/result_ready/result: one item per tick item,
// holding the latched electrode mask and the current pole index.
// Configuration: APB-style port, register 0 (byte address 0) is switch_time,
// the tick count at which the mask is blanked before the pair advances.
// Latency: the result of a tick is valid in the cycle after it is accepted.
// Throughput: one tick per cycle unless stalled; the state update is one pass
// of short logic from the rotator state registers into the result register.
// Stall: tick_ready stays high while the result register is empty or is being
// taken, so a stalled receiver holds back at most one tick.
// Reset: counters, pole index and mask clear to zero, switch_time returns to
// 170, and no result is pending.
module electrode_pair_rotator
    import epr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Tick items
    input  logic              tick_valid,
    output logic              tick_ready,
    input  tick_t             tick,
    // Result items
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] switch_time_val_reg;
    logic       result_valid_reg;
    result_t    result_reg;
    result_t    next_result;
    logic       accept;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SWITCH_TIME);

    // Register index sits at paddr[2]; only index 0 exists
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SWITCH_TIME)
        begin
            prdata = {24'd0, switch_time_val_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_time_val_reg <= SWITCH_TIME_RESET;
        end
        else if (cfg_write)
        begin
            switch_time_val_reg <= pwdata[7:0];
        end
    end

    // Accept a new tick whenever the result register is free or draining
    assign tick_ready = !result_valid_reg || result_ready;
    assign accept     = tick_valid && tick_ready;

    epr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .tick        (tick),
        .switch_time (switch_time_val_reg),
        .next_result (next_result)
    );

    // Hold the result until taken; load the next one on every accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= next_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An accepted tick always leaves a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted tick produced no result");

    // A tick with power and ageing both off resets the pole index
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !tick.power_on && !tick.ageing_test) |=> (result_reg.pole_index == POLE_FIRST))
        else $error("pole index not cleared while off");

    // The heating pole shows all RF channels, or a blanked mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.pole_index == POLE_HEATING) |->
        (result_reg.electrode_mask == (CH_RF1 | CH_RF2 | CH_RF3) ||
         result_reg.electrode_mask == 6'd0))
        else $error("heating pole with wrong mask");

    // An empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg |-> tick_ready)
        else $error("input stalled with empty result register");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import epr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    localparam logic [ADDR_W-1:0] SWITCH_TIME_ADDR = ADDR_W'(4 * int'(REG_SWITCH_TIME));

    logic clk = 1'b0;
    logic rst_n;

    logic              tick_valid;
    logic              tick_ready;
    tick_t             tick;
    logic              result_valid;
    logic              result_ready;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    electrode_pair_rotator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Rotator state as the testbench sees it
    logic [7:0] st_switch;
    logic [7:0] st_count;
    logic [1:0] st_pole;
    logic [1:0] st_next_pole;
    logic [5:0] st_mask;

    // Electrode mask / pole index expected for every accepted tick, oldest first
    result_t predicted_electrodes[$];

    int mismatches      = 0;
    int ticks_accepted  = 0;
    int results_checked = 0;
    int pole_advances   = 0;
    int heating_latches = 0;
    int switch_writes   = 0;
    int quiet_cycles    = 0;

    // Idling controls; changed only at a rising edge so the drivers never race them
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    int hold_requests   = 0;

    // Channel pair for a pole index; pole 3 is the all-RF heating pattern
    function automatic logic [5:0] pole_channels(input logic [1:0] pole, input logic repair);
        case (pole)
            POLE_FIRST:  return repair ? (CH_RF1 | CH_RF2) : (CH_RF1 | CH_RF2 | CH_EMS2);
            POLE_SECOND: return repair ? (CH_RF2 | CH_RF3) : (CH_RF2 | CH_RF3 | CH_EMS3);
            POLE_LAST:   return repair ? (CH_RF1 | CH_RF3) : (CH_RF1 | CH_RF3 | CH_EMS1);
            default:     return CH_RF1 | CH_RF2 | CH_RF3;
        endcase
    endfunction

    // Advance the rotator by one tick and return what it shows afterwards
    function automatic result_t rotate_tick(input tick_t t);
        result_t r;
        if (t.power_on || t.ageing_test)
        begin
            if (t.rf_running || t.ems_running)
            begin
                st_count = st_count + 8'd1;
                if (st_count == st_switch)
                    st_mask = '0;
                else if ({1'b0, st_count} > {1'b0, st_switch} + ADVANCE_GAP)
                begin
                    // restart the count; index 3 steps to 0 just like index 2
                    st_count = '0;
                    st_pole  = (st_pole >= POLE_LAST) ? POLE_FIRST : st_pole + 2'd1;
                    pole_advances++;
                end
            end
            else
            begin
                // powered but idle: clear and blank, pair check still runs below
                st_count = '0;
                st_pole  = POLE_FIRST;
                st_mask  = '0;
            end
            if (st_pole == st_next_pole)
            begin
                st_next_pole = (st_pole == POLE_LAST) ? POLE_FIRST : st_pole + 2'd1;
                if (t.heating && t.repair_work)
                begin
                    st_pole      = POLE_HEATING;
                    st_next_pole = POLE_FIRST;
                    heating_latches++;
                end
                st_mask = pole_channels(st_pole, t.repair_work);
            end
        end
        else
        begin
            // off: counters clear, mask holds
            st_count     = '0;
            st_pole      = POLE_FIRST;
            st_next_pole = POLE_FIRST;
        end
        r.electrode_mask = st_mask;
        r.pole_index     = st_pole;
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Gap length: mostly short, now and then long
    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(1, 3);
        else if (p < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Powered (or ageing) tick with at least one driver running, random
    // heating and repair; noise_pct of the items are fully random flags
    function automatic tick_t powered_tick(input int noise_pct);
        tick_t      t;
        logic [1:0] drivers;
        if ($urandom_range(0, 99) < noise_pct)
            return tick_t'(6'($urandom_range(0, 63)));
        drivers       = 2'($urandom_range(1, 3));
        t.power_on    = ($urandom_range(0, 7) != 0);
        t.ageing_test = t.power_on ? 1'($urandom_range(0, 1)) : 1'b1;
        t.rf_running  = drivers[0];
        t.ems_running = drivers[1];
        t.heating     = ($urandom_range(0, 3) == 0);
        t.repair_work = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic tick_t make_tick(input logic on, input logic ageing, input logic rf,
                                        input logic ems, input logic heat, input logic repair);
        tick_t t;
        t.power_on    = on;
        t.ageing_test = ageing;
        t.rf_running  = rf;
        t.ems_running = ems;
        t.heating     = heat;
        t.repair_work = repair;
        return t;
    endfunction

    // Offer one tick item; call and return at a falling edge. Valid stays
    // high on return so a back-to-back item keeps it high without a dip.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = (sender_gaps && $urandom_range(0, 99) < 35) ? idle_gap() : 0;
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick       <= t;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted item has come back
    task automatic wait_idle();
        tick_valid <= 1'b0;
        while (predicted_electrodes.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_idling(input bit gaps, input bit stalls);
        @(posedge clk);
        sender_gaps     = gaps;
        receiver_stalls = stalls;
        @(negedge clk);
    endtask

    // Write switch_time, then read it back; block must be idle
    task automatic write_switch_time(input logic [7:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SWITCH_TIME_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        st_switch = value;
        switch_writes++;
        // hold psel for a read right behind the write
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[7:0] !== value)
            log_mismatch($sformatf("switch_time read back %0d, expected %0d",
                                   readback[7:0], value));
    endtask

    // Check each result item against the oldest prediction, then predict
    // for a tick accepted at the same edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_checked++;
                if (predicted_electrodes.size() == 0)
                    log_mismatch($sformatf("unexpected result mask %b pole %0d",
                                           result.electrode_mask, result.pole_index));
                else
                begin
                    want = predicted_electrodes.pop_front();
                    if (result.electrode_mask !== want.electrode_mask)
                        log_mismatch($sformatf("result %0d electrode_mask: expected %b, got %b",
                                               results_checked, want.electrode_mask,
                                               result.electrode_mask));
                    if (result.pole_index !== want.pole_index)
                        log_mismatch($sformatf("result %0d pole_index: expected %0d, got %0d",
                                               results_checked, want.pole_index,
                                               result.pole_index));
                end
            end
            if (tick_valid && tick_ready)
            begin
                ticks_accepted++;
                predicted_electrodes.push_back(rotate_tick(tick));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        int stall_left;
        int hold_left;
        int holds_served;
        stall_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_gap() - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog: end the run after too long without any handshake
    always @(posedge clk)
    begin
        if ((tick_valid && tick_ready) || (result_valid && result_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: %0d cycles without a handshake", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Flags at the extremes, every special case of the rotation
    task automatic test_directed();
        // default switch_time: off, powered with no driver, everything on
        send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        wait_idle();
        // switch_time of 1: four ticks per advance
        write_switch_time(8'd1);
        repeat (4) send_tick(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        // ageing alone keeps the rotation going; repair pair without EMS
        repeat (4) send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
        // heating in repair forces all RF channels
        repeat (4) send_tick(make_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        // advance out of the heating pattern; heating alone has no effect
        repeat (4) send_tick(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
        // drivers stop, then power drops with drivers still flagged
        send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        wait_idle();
    endtask

    // Receiver holds off while ticks keep coming, so the input stalls
    task automatic test_backpressure();
        write_switch_time(8'd3);
        set_idling(1'b0, 1'b1);
        @(posedge clk);
        hold_requests = hold_requests + 1;
        @(negedge clk);
        repeat (20) send_tick(powered_tick(5));
        wait_idle();
        set_idling(1'b1, 1'b1);
    endtask

    // Long run at the top of the counter range so it wraps, then short
    // phases at small, zero and large switch_time
    task automatic test_random_phases();
        logic [7:0] short_settings [6];
        short_settings = '{8'd0, 8'd252, 8'd2, 8'd1, 8'd5, 8'd3};
        short_settings[5] = 8'($urandom_range(3, 12));

        write_switch_time(8'($urandom_range(253, 255)));
        repeat (260) send_tick(powered_tick(1));
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            // one stretch with no idling on either side
            set_idling(ph != 2, ph != 2);
            write_switch_time(short_settings[ph]);
            repeat (28) send_tick(powered_tick(15));
            wait_idle();
        end
        set_idling(1'b1, 1'b1);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        tick_valid = 1'b0;
        tick       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        st_switch    = SWITCH_TIME_RESET;
        st_count     = '0;
        st_pole      = POLE_FIRST;
        st_next_pole = POLE_FIRST;
        st_mask      = '0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (4) @(negedge clk);
        mismatches += predicted_electrodes.size();

        $display("Run covered %0d tick items and %0d checked results over %0d switch_time writes.",
                 ticks_accepted, results_checked, switch_writes);
        $display("Rotator made %0d pair advances and %0d heating latches; %0d mismatches.",
                 pole_advances, heating_latches, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
